>>> src/nff_pkg.sv
`default_nettype none
package nff_pkg;

   localparam int MAX_WIDTH     = 32;
   localparam int MAX_PRECISION = 12;
   localparam int DEC_DIGITS    = 10;
   localparam int HEX_DIGITS    = 8;

   // Reciprocal of ten scaled by 2^35, used for the divide-by-ten step.
   localparam logic [31:0] RECIP_TEN = 32'hcccccccd;
   localparam int          RECIP_SHIFT = 35;

   localparam logic [2:0] OP_SDEC  = 3'd0;
   localparam logic [2:0] OP_UDEC  = 3'd1;
   localparam logic [2:0] OP_HEX   = 3'd2;
   localparam logic [2:0] OP_ZHEX  = 3'd3;
   localparam logic [2:0] OP_FIXED = 3'd4;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_MINUS = 8'h2d;
   localparam logic [7:0] CHAR_POINT = 8'h2e;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_A     = 8'h61;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FRAC,
      S_ROUND,
      S_DEC,
      S_LEN,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic frac_step;
      logic round_step;
      logic dec_step;
      logic len_calc;
      logic emit_step;
   } cmd_type;

   typedef struct packed {
      logic frac_done;
      logic round_done;
      logic dec_done;
      logic total_zero;
      logic emit_last;
   } sts_type;

   function automatic logic [7:0] digit_char(input logic [3:0] d);
      logic [7:0] c;
      if (d < 4'd10) begin
         c = CHAR_ZERO + {4'd0, d};
      end else begin
         c = CHAR_A + {4'd0, d} - 8'd10;
      end
      return c;
   endfunction

endpackage
`default_nettype wire

>>> src/numeric_field_formatter.sv
`default_nettype none
// Numeric field formatter: one request in, one character word per cycle out.
// Steps: decimal modes convert one digit per step (up to 10); fixed mode first runs fraction steps
// (precision digits plus a rounding digit) and then rounding steps; hex modes skip all of these.
// One length step follows, then the emission state; words are registered, one word per cycle.
// Throughput: one request per field; busy falls in the cycle that carries the last word.
// Reset is synchronous and active high; it returns the block to idle. The receiver cannot stall.
module numeric_field_formatter (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [2:0]  req_opcode,
   input  wire logic [31:0] req_value,
   input  wire logic [5:0]  req_width,
   input  wire logic [3:0]  req_precision,
   input  wire logic [7:0]  req_pad_char,
   output logic             rsp_strobe,
   output logic [7:0]       rsp_out_char,
   output logic             rsp_last
);

   nff_pkg::cmd_type cmd;
   nff_pkg::sts_type sts;

   nff_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_opcode (req_opcode),
      .sts        (sts),
      .cmd        (cmd),
      .busy       (busy)
   );

   nff_datapath u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_opcode    (req_opcode),
      .req_value     (req_value),
      .req_width     (req_width),
      .req_precision (req_precision),
      .req_pad_char  (req_pad_char),
      .sts           (sts),
      .rsp_strobe    (rsp_strobe),
      .rsp_out_char  (rsp_out_char),
      .rsp_last      (rsp_last)
   );

endmodule
`default_nettype wire

>>> src/nff_controller.sv
`default_nettype none
module nff_controller (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [2:0]       req_opcode,
   input  nff_pkg::sts_type      sts,
   output nff_pkg::cmd_type      cmd,
   output logic                  busy
);

   nff_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nff_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         nff_pkg::S_IDLE: begin
            if (start) begin
               case (req_opcode)
                  nff_pkg::OP_SDEC, nff_pkg::OP_UDEC: state_in = nff_pkg::S_DEC;
                  nff_pkg::OP_HEX, nff_pkg::OP_ZHEX:  state_in = nff_pkg::S_LEN;
                  nff_pkg::OP_FIXED:                  state_in = nff_pkg::S_FRAC;
                  default:                            state_in = nff_pkg::S_IDLE;
               endcase
            end
         end
         nff_pkg::S_FRAC:  if (sts.frac_done) state_in = nff_pkg::S_ROUND;
         nff_pkg::S_ROUND: if (sts.round_done) state_in = nff_pkg::S_DEC;
         nff_pkg::S_DEC:   if (sts.dec_done) state_in = nff_pkg::S_LEN;
         nff_pkg::S_LEN: begin
            state_in = sts.total_zero ? nff_pkg::S_IDLE : nff_pkg::S_EMIT;
         end
         nff_pkg::S_EMIT:  if (sts.emit_last) state_in = nff_pkg::S_IDLE;
         default:          state_in = nff_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      busy = 1'b1;
      case (state_ff)
         nff_pkg::S_IDLE: begin
            busy = 1'b0;
            cmd.load = start;
         end
         nff_pkg::S_FRAC:  cmd.frac_step = 1'b1;
         nff_pkg::S_ROUND: cmd.round_step = 1'b1;
         nff_pkg::S_DEC:   cmd.dec_step = 1'b1;
         nff_pkg::S_LEN:   cmd.len_calc = 1'b1;
         nff_pkg::S_EMIT:  cmd.emit_step = 1'b1;
         default:          busy = 1'b0;
      endcase
   end

endmodule
`default_nettype wire

>>> src/nff_datapath.sv
`default_nettype none
module nff_datapath (
   input  wire logic             clock,
   input  wire logic             reset,
   input  nff_pkg::cmd_type      cmd,
   input  wire logic [2:0]       req_opcode,
   input  wire logic [31:0]      req_value,
   input  wire logic [5:0]       req_width,
   input  wire logic [3:0]       req_precision,
   input  wire logic [7:0]       req_pad_char,
   output nff_pkg::sts_type      sts,
   output logic                  rsp_strobe,
   output logic [7:0]            rsp_out_char,
   output logic                  rsp_last
);

   logic [2:0]  op_ff;
   logic [5:0]  width_ff;
   logic [3:0]  prec_ff;
   logic [7:0]  pad_ff;
   logic        neg_ff;
   logic [31:0] mag_ff;
   logic [15:0] f_ff;
   logic [3:0]  fcnt_ff;
   logic [3:0]  frac_ff [nff_pkg::MAX_PRECISION];
   logic        carry_ff;
   logic [3:0]  ridx_ff;
   logic [31:0] dec_ff;
   logic [3:0]  rev_ff [nff_pkg::DEC_DIGITS];
   logic [3:0]  nd_ff;
   logic [5:0]  npad_ff;
   logic [5:0]  total_ff;
   logic [5:0]  pos_ff;
   logic        strobe_ff;
   logic [7:0]  char_ff;
   logic        last_ff;

   // Load-time decode.
   logic        neg_in;
   logic [31:0] mag_in;
   logic [3:0]  prec_in;
   logic [3:0]  hex_nd;

   always_comb begin
      neg_in = req_value[31] &&
               (req_opcode == nff_pkg::OP_SDEC || req_opcode == nff_pkg::OP_FIXED);
      mag_in = neg_in ? (32'd0 - req_value) : req_value;
      prec_in = (req_precision > 4'(nff_pkg::MAX_PRECISION)) ?
                4'(nff_pkg::MAX_PRECISION) : req_precision;
      hex_nd = 4'd1;
      for (int i = 1; i < nff_pkg::HEX_DIGITS; i++) begin
         if (req_value[4*i +: 4] != 4'd0) hex_nd = 4'(i + 1);
      end
      if (req_opcode == nff_pkg::OP_ZHEX) begin
         hex_nd = (req_width > 6'd8) ? 4'd8 : req_width[3:0];
      end
   end

   // Fraction digit step: multiply the remaining fraction by ten.
   logic [19:0] fprod;
   assign fprod = {4'd0, f_ff} * 20'd10;

   // Divide-by-ten step on the integer part.
   logic [63:0] qprod;
   logic [31:0] quot;
   logic [3:0]  rem;
   assign qprod = {32'd0, dec_ff} * {32'd0, nff_pkg::RECIP_TEN};
   assign quot = 32'(qprod >> nff_pkg::RECIP_SHIFT);
   assign rem = 4'(dec_ff - (quot << 3) - (quot << 1));

   // Field length.
   logic [5:0] body_len;
   logic [5:0] wcap;
   logic [5:0] npad_calc;
   always_comb begin
      body_len = {5'd0, neg_ff} + {2'd0, nd_ff};
      if (op_ff == nff_pkg::OP_FIXED && prec_ff != 4'd0) begin
         body_len = body_len + 6'd1 + {2'd0, prec_ff};
      end
      wcap = (width_ff > 6'(nff_pkg::MAX_WIDTH)) ? 6'(nff_pkg::MAX_WIDTH) : width_ff;
      npad_calc = (wcap > body_len && op_ff != nff_pkg::OP_ZHEX) ? (wcap - body_len) : 6'd0;
   end

   // Character at the current emission position.
   logic [5:0] bpos;
   logic [5:0] dpos;
   logic [7:0] cur_char;
   always_comb begin
      bpos = pos_ff - npad_ff;
      dpos = bpos - {5'd0, neg_ff};
      if (pos_ff < npad_ff) begin
         cur_char = (op_ff == nff_pkg::OP_SDEC) ? nff_pkg::CHAR_SPACE : pad_ff;
      end else if (neg_ff && bpos == 6'd0) begin
         cur_char = nff_pkg::CHAR_MINUS;
      end else if (dpos < {2'd0, nd_ff}) begin
         cur_char = nff_pkg::digit_char(rev_ff[4'({2'd0, nd_ff} - 6'd1 - dpos)]);
      end else if (dpos == {2'd0, nd_ff}) begin
         cur_char = nff_pkg::CHAR_POINT;
      end else begin
         cur_char = nff_pkg::digit_char(frac_ff[4'(dpos - {2'd0, nd_ff} - 6'd1)]);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= req_opcode;
         width_ff <= req_width;
         prec_ff <= prec_in;
         pad_ff <= req_pad_char;
         neg_ff <= neg_in;
         mag_ff <= mag_in;
         f_ff <= mag_in[15:0];
         fcnt_ff <= 4'd0;
         dec_ff <= mag_in;
         nd_ff <= (req_opcode == nff_pkg::OP_HEX || req_opcode == nff_pkg::OP_ZHEX) ?
                  hex_nd : 4'd0;
         for (int i = 0; i < nff_pkg::HEX_DIGITS; i++) begin
            rev_ff[i] <= req_value[4*i +: 4];
         end
      end
      if (cmd.frac_step) begin
         f_ff <= fprod[15:0];
         fcnt_ff <= fcnt_ff + 4'd1;
         if (fcnt_ff == prec_ff) begin
            carry_ff <= (fprod[19:16] > 4'd4);
            ridx_ff <= prec_ff;
         end else begin
            frac_ff[fcnt_ff] <= fprod[19:16];
         end
      end
      if (cmd.round_step) begin
         if (carry_ff && ridx_ff != 4'd0) begin
            ridx_ff <= ridx_ff - 4'd1;
            if (frac_ff[ridx_ff - 4'd1] >= 4'd9) begin
               frac_ff[ridx_ff - 4'd1] <= 4'd0;
            end else begin
               frac_ff[ridx_ff - 4'd1] <= frac_ff[ridx_ff - 4'd1] + 4'd1;
               carry_ff <= 1'b0;
            end
         end else begin
            dec_ff <= {16'd0, mag_ff[31:16]} + {31'd0, carry_ff};
         end
      end
      if (cmd.dec_step) begin
         rev_ff[nd_ff] <= rem;
         nd_ff <= nd_ff + 4'd1;
         dec_ff <= quot;
      end
      if (cmd.len_calc) begin
         npad_ff <= npad_calc;
         total_ff <= npad_calc + body_len;
         pos_ff <= 6'd0;
      end
      if (cmd.emit_step) begin
         pos_ff <= pos_ff + 6'd1;
      end
      char_ff <= cur_char;
      last_ff <= (pos_ff == total_ff - 6'd1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.emit_step;
      end
   end

   always_comb begin
      sts.frac_done = (fcnt_ff == prec_ff);
      sts.round_done = !(carry_ff && ridx_ff != 4'd0);
      sts.dec_done = (quot == 32'd0) || (nd_ff == 4'(nff_pkg::DEC_DIGITS - 1));
      sts.total_zero = ((npad_calc + body_len) == 6'd0);
      sts.emit_last = (pos_ff == total_ff - 6'd1);
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_out_char = char_ff;
   assign rsp_last = last_ff;

endmodule
`default_nettype wire
